FILE: src/spi_flash_slave_model_defines.svh
// Assertion macros shared by the RTL files.
`ifndef SPI_FLASH_SLAVE_MODEL_DEFINES_SVH
`define SPI_FLASH_SLAVE_MODEL_DEFINES_SVH

`ifndef ASSERT_OFF
`define SFSM_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) \
    else $error("assertion failed");
`define SFSM_ASSERT_NORST(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) (prop)) \
    else $error("assertion failed");
`else
`define SFSM_ASSERT(lbl, ck, rs, prop)
`define SFSM_ASSERT_NORST(lbl, ck, prop)
`endif

`endif

FILE: src/sfsm_pkg.sv
`default_nettype none

package sfsm_pkg;

  typedef struct packed {
    logic select_n;
    logic sclk;
    logic mosi;
  } in_t;

  typedef struct packed {
    logic miso;
    logic write_enabled;
  } out_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_CMD,
    PH_ADDR1,
    PH_ADDR2,
    PH_ADDR3,
    PH_PROGRAM,
    PH_READ,
    PH_RESPOND,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    EW_LOW_THEN_HIGH,
    EW_HIGH,
    EW_HIGH_THEN_LOW,
    EW_LOW
  } edge_wait_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_READY,
    ST_ERASE
  } store_state_t;

  typedef struct packed {
    logic        wr_en;
    logic [23:0] wr_addr;
    logic [7:0]  wr_data;
    logic        rd_en;
    logic [23:0] rd_addr;
    logic        erase_start;
    logic [23:0] erase_first;
  } mem_req_t;

  localparam logic [7:0] CMD_PROGRAM = 8'h02;
  localparam logic [7:0] CMD_READ    = 8'h03;
  localparam logic [7:0] CMD_STATUS  = 8'h05;
  localparam logic [7:0] CMD_WREN    = 8'h06;
  localparam logic [7:0] CMD_ERASE   = 8'h20;
  localparam logic [7:0] CMD_ID      = 8'h90;

  localparam logic [0:0] CFG_ID_FIRST  = 1'b0;
  localparam logic [0:0] CFG_ID_SECOND = 1'b1;

  localparam logic [7:0] ID_FIRST_RESET  = 8'hAB;
  localparam logic [7:0] ID_SECOND_RESET = 8'hCD;

  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [3:0] BYTE_BITS  = 4'd8;

endpackage

`default_nettype wire

FILE: src/sfsm_store.sv
`default_nettype none
`include "spi_flash_slave_model_defines.svh"

module sfsm_store #(
  parameter int FLASH_BYTES  = 65536,
  parameter int SECTOR_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  sfsm_pkg::mem_req_t req,
  output logic [7:0]        rdata,
  output logic              busy
);
  import sfsm_pkg::*;

  localparam int AW = $clog2(FLASH_BYTES);
  localparam int SW = $clog2(SECTOR_BYTES);
  localparam logic [23:0]   LAST_ADDR = 24'(FLASH_BYTES - 1);
  localparam logic [SW-1:0] SECT_LAST = '1;

  logic [7:0] mem [FLASH_BYTES];

  store_state_t state, state_next;
  logic [23:0]  sweep_addr, sweep_addr_next;
  logic         sweep_end;
  logic         we;
  logic [AW-1:0] waddr;
  logic [7:0]   wdata;

  always_comb begin
    if (state == ST_CLEAR) begin
      sweep_end = (sweep_addr == LAST_ADDR);
    end else begin
      sweep_end = (sweep_addr[SW-1:0] == SECT_LAST) || (sweep_addr == LAST_ADDR);
    end
  end

  always_comb begin : next_state
    state_next      = state;
    sweep_addr_next = sweep_addr;
    unique case (state)
      ST_CLEAR, ST_ERASE: begin
        sweep_addr_next = sweep_addr + 24'd1;
        if (sweep_end) begin
          state_next = ST_READY;
        end
      end
      ST_READY: begin
        if (req.erase_start) begin
          state_next      = ST_ERASE;
          sweep_addr_next = req.erase_first;
        end
      end
      default: begin
        state_next = ST_READY;
      end
    endcase
  end

  always_comb begin : outputs
    busy  = (state != ST_READY);
    we    = 1'b0;
    waddr = req.wr_addr[AW-1:0];
    wdata = req.wr_data;
    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = sweep_addr[AW-1:0];
        wdata = BYTE_ZERO;
      end
      ST_ERASE: begin
        we    = 1'b1;
        waddr = sweep_addr[AW-1:0];
        wdata = BYTE_ONES;
      end
      ST_READY: begin
        we = req.wr_en;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      sweep_addr <= '0;
    end else begin
      state      <= state_next;
      sweep_addr <= sweep_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr[AW-1:0]];
    end
  end

  `SFSM_ASSERT(a_erase_when_ready, clk, rst, req.erase_start |-> state == ST_READY)
  `SFSM_ASSERT(a_access_when_ready, clk, rst, (req.wr_en || req.rd_en) |-> state == ST_READY)

endmodule

`default_nettype wire

FILE: src/sfsm_core.sv
`default_nettype none
`include "spi_flash_slave_model_defines.svh"

module sfsm_core #(
  parameter int FLASH_BYTES  = 65536,
  parameter int SECTOR_BYTES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  sfsm_pkg::in_t      sample,
  input  logic [7:0]         id_first,
  input  logic [7:0]         id_second,
  input  logic [7:0]         rdata,
  output sfsm_pkg::mem_req_t req,
  output sfsm_pkg::out_t     result,
  output logic               fetch_pending
);
  import sfsm_pkg::*;

  localparam logic [24:0] FLASH_END = 25'(FLASH_BYTES);
  localparam logic [23:0] SECT_MASK = ~24'(SECTOR_BYTES - 1);

  phase_t     phase, phase_next;
  edge_wait_t edge_wait, edge_wait_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  command_byte, command_byte_next;
  logic [24:0] byte_address, byte_address_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [1:0]  response_count, response_count_next;
  logic        write_latch, write_latch_next;
  logic        miso_level, miso_level_next;
  logic        fetch_pending_next;
  logic        fetch_oob, fetch_oob_next;

  edge_wait_t ew_rx, ew_tx;
  logic        rx_edge, tx_edge, rx_full, tx_full;
  logic [3:0]  cnt_rx, cnt_tx;
  logic [7:0]  shift_rx, shift_tx;
  logic        miso_tx;
  logic [24:0] addr_shifted;
  logic [23:0] sector_first;
  logic        addr_ok, shifted_ok, first_ok, live;
  logic        ev_prog, ev_fetch_addr, ev_fetch_read, ev_erase;

  always_comb begin : helpers
    rx_edge  = (edge_wait == EW_HIGH) && sample.sclk;
    tx_edge  = (edge_wait == EW_LOW) && !sample.sclk;
    ew_rx    = edge_wait;
    if (edge_wait == EW_LOW_THEN_HIGH && !sample.sclk) begin
      ew_rx = EW_HIGH;
    end else if (rx_edge) begin
      ew_rx = EW_LOW_THEN_HIGH;
    end
    ew_tx = edge_wait;
    if (edge_wait == EW_HIGH_THEN_LOW && sample.sclk) begin
      ew_tx = EW_LOW;
    end else if (tx_edge) begin
      ew_tx = EW_HIGH_THEN_LOW;
    end
    cnt_rx   = rx_edge ? bit_count + 4'd1 : bit_count;
    cnt_tx   = tx_edge ? bit_count + 4'd1 : bit_count;
    rx_full  = (cnt_rx == BYTE_BITS);
    tx_full  = (cnt_tx == BYTE_BITS);
    shift_rx = rx_edge ? {shift_byte[6:0], sample.mosi} : shift_byte;
    shift_tx = tx_edge ? {shift_byte[6:0], 1'b0} : shift_byte;
    miso_tx  = tx_edge ? shift_byte[7] : miso_level;

    addr_shifted = {1'b0, byte_address[15:0], shift_rx};
    sector_first = addr_shifted[23:0] & SECT_MASK;
    addr_ok      = byte_address < FLASH_END;
    shifted_ok   = addr_shifted < FLASH_END;
    first_ok     = {1'b0, sector_first} < FLASH_END;

    live          = take && !sample.select_n;
    ev_prog       = live && phase == PH_PROGRAM && rx_full && addr_ok;
    ev_fetch_addr = live && phase == PH_ADDR3 && rx_full && command_byte == CMD_READ;
    ev_fetch_read = live && phase == PH_READ && tx_full;
    ev_erase      = live && phase == PH_ADDR3 && rx_full && command_byte == CMD_ERASE
                    && first_ok;
  end

  always_comb begin : next_state
    phase_next          = phase;
    edge_wait_next      = edge_wait;
    bit_count_next      = bit_count;
    command_byte_next   = command_byte;
    byte_address_next   = byte_address;
    shift_byte_next     = shift_byte;
    response_count_next = response_count;
    write_latch_next    = write_latch;
    miso_level_next     = miso_level;
    fetch_pending_next  = fetch_pending;
    fetch_oob_next      = fetch_oob;

    if (fetch_pending) begin
      shift_byte_next    = fetch_oob ? BYTE_ONES : rdata;
      fetch_pending_next = 1'b0;
    end else if (take) begin
      if (sample.select_n) begin
        phase_next          = PH_IDLE;
        command_byte_next   = '0;
        byte_address_next   = '0;
        shift_byte_next     = '0;
        bit_count_next      = '0;
        response_count_next = '0;
      end else begin
        unique case (phase)
          PH_IDLE: begin
            phase_next      = PH_CMD;
            edge_wait_next  = sample.sclk ? EW_LOW_THEN_HIGH : EW_HIGH;
            bit_count_next  = '0;
            shift_byte_next = '0;
          end
          PH_CMD: begin
            edge_wait_next  = ew_rx;
            bit_count_next  = cnt_rx;
            shift_byte_next = shift_rx;
            if (rx_full) begin
              command_byte_next = shift_rx;
              unique case (shift_rx) inside
                CMD_PROGRAM, CMD_READ, CMD_ERASE, CMD_ID: begin
                  phase_next      = PH_ADDR1;
                  bit_count_next  = '0;
                  shift_byte_next = '0;
                  edge_wait_next  = EW_LOW_THEN_HIGH;
                end
                CMD_STATUS: begin
                  response_count_next = '0;
                  phase_next          = PH_RESPOND;
                  shift_byte_next     = {6'b0, write_latch, 1'b0};
                  bit_count_next      = '0;
                  edge_wait_next      = EW_LOW;
                end
                CMD_WREN: begin
                  write_latch_next = 1'b1;
                  phase_next       = PH_DONE;
                end
                default: begin
                  phase_next = PH_DONE;
                end
              endcase
            end
          end
          PH_ADDR1, PH_ADDR2, PH_ADDR3: begin
            edge_wait_next  = ew_rx;
            bit_count_next  = cnt_rx;
            shift_byte_next = shift_rx;
            if (rx_full) begin
              byte_address_next = addr_shifted;
              if (phase == PH_ADDR3) begin
                unique case (command_byte) inside
                  CMD_PROGRAM: begin
                    phase_next      = PH_PROGRAM;
                    bit_count_next  = '0;
                    shift_byte_next = '0;
                    edge_wait_next  = EW_LOW_THEN_HIGH;
                  end
                  CMD_READ: begin
                    phase_next         = PH_READ;
                    bit_count_next     = '0;
                    edge_wait_next     = EW_LOW;
                    fetch_pending_next = 1'b1;
                    fetch_oob_next     = !shifted_ok;
                    if (shifted_ok) begin
                      byte_address_next = addr_shifted + 25'd1;
                    end
                  end
                  CMD_ID: begin
                    response_count_next = '0;
                    phase_next          = PH_RESPOND;
                    shift_byte_next     = id_first;
                    bit_count_next      = '0;
                    edge_wait_next      = EW_LOW;
                  end
                  default: begin
                    phase_next = PH_DONE;
                  end
                endcase
              end else begin
                phase_next      = (phase == PH_ADDR1) ? PH_ADDR2 : PH_ADDR3;
                bit_count_next  = '0;
                shift_byte_next = '0;
                edge_wait_next  = EW_LOW_THEN_HIGH;
              end
            end
          end
          PH_PROGRAM: begin
            edge_wait_next  = ew_rx;
            bit_count_next  = cnt_rx;
            shift_byte_next = shift_rx;
            if (rx_full) begin
              if (addr_ok) begin
                byte_address_next = byte_address + 25'd1;
              end
              bit_count_next  = '0;
              shift_byte_next = '0;
            end
          end
          PH_READ: begin
            edge_wait_next  = ew_tx;
            bit_count_next  = cnt_tx;
            shift_byte_next = shift_tx;
            miso_level_next = miso_tx;
            if (tx_full) begin
              bit_count_next     = '0;
              fetch_pending_next = 1'b1;
              fetch_oob_next     = !addr_ok;
              if (addr_ok) begin
                byte_address_next = byte_address + 25'd1;
              end
            end
          end
          PH_RESPOND: begin
            edge_wait_next  = ew_tx;
            bit_count_next  = cnt_tx;
            shift_byte_next = shift_tx;
            miso_level_next = miso_tx;
            if (tx_full) begin
              response_count_next = response_count + 2'd1;
              if (command_byte == CMD_ID && response_count + 2'd1 == 2'd1) begin
                shift_byte_next = id_second;
                bit_count_next  = '0;
              end else begin
                phase_next = PH_DONE;
              end
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  always_comb begin : outputs
    req.wr_en       = ev_prog;
    req.wr_addr     = byte_address[23:0];
    req.wr_data     = shift_rx;
    req.rd_en       = (ev_fetch_addr && shifted_ok) || (ev_fetch_read && addr_ok);
    req.rd_addr     = ev_fetch_addr ? addr_shifted[23:0] : byte_address[23:0];
    req.erase_start = ev_erase;
    req.erase_first = sector_first;
    result.miso          = miso_level_next;
    result.write_enabled = write_latch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      edge_wait      <= EW_HIGH;
      bit_count      <= '0;
      command_byte   <= '0;
      byte_address   <= '0;
      shift_byte     <= '0;
      response_count <= '0;
      write_latch    <= 1'b0;
      miso_level     <= 1'b0;
      fetch_pending  <= 1'b0;
      fetch_oob      <= 1'b0;
    end else begin
      phase          <= phase_next;
      edge_wait      <= edge_wait_next;
      bit_count      <= bit_count_next;
      command_byte   <= command_byte_next;
      byte_address   <= byte_address_next;
      shift_byte     <= shift_byte_next;
      response_count <= response_count_next;
      write_latch    <= write_latch_next;
      miso_level     <= miso_level_next;
      fetch_pending  <= fetch_pending_next;
      fetch_oob      <= fetch_oob_next;
    end
  end

  `SFSM_ASSERT(a_fetch_interlock, clk, rst, fetch_pending |-> !take)
  `SFSM_ASSERT(a_tx_edge_wait, clk, rst, (phase == PH_READ || phase == PH_RESPOND) |-> (edge_wait == EW_LOW || edge_wait == EW_HIGH_THEN_LOW))

endmodule

`default_nettype wire

FILE: src/spi_flash_slave_model.sv
// Channel   Direction  Handshake                    Payload
// sample    in         sample_valid / sample_stall  sfsm_pkg::in_t  (select_n, sclk, mosi)
// result    out        result_valid / result_stall  sfsm_pkg::out_t (miso, write_enabled)
// cfg       in         cfg_we                       cfg_index, cfg_data (id bytes)
//
// One pin sample per cycle while sample_stall is low, one result per sample, held in an output register.
// A flash byte fetch (read command) stalls samples while the registered array read port returns it.
// Sector erase writes one byte per cycle, from the sector's first byte to its last, with sample_stall high.
// After reset the array is cleared to zero with sample_stall high.
// Reset is synchronous; cfg writes are taken at any time.
`default_nettype none
`include "spi_flash_slave_model_defines.svh"

module spi_flash_slave_model #(
  parameter int FLASH_BYTES  = 65536,
  parameter int SECTOR_BYTES = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           sample_valid,
  output logic           sample_stall,
  input  sfsm_pkg::in_t  sample,
  output logic           result_valid,
  input  logic           result_stall,
  output sfsm_pkg::out_t result,
  input  logic           cfg_we,
  input  logic [0:0]     cfg_index,
  input  logic [7:0]     cfg_data
);
  import sfsm_pkg::*;

  logic [7:0] id_first, id_second;
  logic       take;
  logic       store_busy;
  logic       fetch_pending;
  logic [7:0] rdata;
  mem_req_t   req;
  out_t       core_result;

  assign sample_stall = store_busy || fetch_pending || (result_valid && result_stall);
  assign take         = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_first  <= ID_FIRST_RESET;
      id_second <= ID_SECOND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ID_FIRST:  id_first  <= cfg_data;
        CFG_ID_SECOND: id_second <= cfg_data;
      endcase
    end
  end

  sfsm_core #(
    .FLASH_BYTES  (FLASH_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .sample        (sample),
    .id_first      (id_first),
    .id_second     (id_second),
    .rdata         (rdata),
    .req           (req),
    .result        (core_result),
    .fetch_pending (fetch_pending)
  );

  sfsm_store #(
    .FLASH_BYTES  (FLASH_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rdata (rdata),
    .busy  (store_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= core_result;
    end
  end

  `SFSM_ASSERT(a_take_gives_result, clk, rst, take |=> result_valid)
  `SFSM_ASSERT_NORST(a_reset_clears_result, clk, rst |=> !result_valid)

endmodule

`default_nettype wire
